// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every module under rtl/.
package rau_pkg;

  localparam int WORD_W = 32;  // operand and result numerator width
  localparam int DEN_W  = 31;  // result denominator width
  localparam int WIDE_W = 64;  // cross-product and reduction width
  localparam int CNT_W  = 6;   // bit counter and shift count for WIDE_W

  localparam logic [WIDE_W-1:0] NUM_POS_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [WIDE_W-1:0] NUM_NEG_MAX = 64'h0000_0000_8000_0000;
  localparam logic [WIDE_W-1:0] DEN_MAX     = 64'h0000_0000_7FFF_FFFF;

  typedef enum logic [2:0] {
    KIND_NORM   = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_SUB    = 3'd2,
    KIND_MUL    = 3'd3,
    KIND_DIV    = 3'd4,
    KIND_NEG    = 3'd5,
    KIND_EQ     = 3'd6,
    KIND_UNUSED = 3'd7   // answered with an all-zero result
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_ADD,
    S_EQ,
    S_REDUCE,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FINISH,
    S_OUT
  } state_e;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: top level with sequencer, shared multiplier and adder.
// Depends on rau_pkg, rau_gcd and rau_div.
//
// One request at a time: in_ready_o is high only while the sequencer is idle.
// An unused kind, a zero denominator or a divide by zero goes straight from the
// check to the output step, a zero numerator skips the reduction, and other
// requests but compares run through the gcd and the divider; the sequencer
// returns to idle on the edge that loads the result. The long path is set by the
// binary gcd unit (one shift or subtract step per cycle) followed by two passes
// through the bit-serial divider for numerator and denominator. Cross
// products go through a single 32x32 multiplier, one product per cycle, then
// one 64-bit sign-magnitude add. Equality is decided by cross-multiplying, so
// it never enters the gcd or divider. The result sits in an output register,
// so a new request is taken while the previous result waits for out_ready_i;
// the sequencer only stalls at its last step if that register is still full.
module rational_arithmetic_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  kind_i,
  input  logic signed [rau_pkg::WORD_W-1:0] a_num_i,
  input  logic signed [rau_pkg::WORD_W-1:0] a_den_i,
  input  logic signed [rau_pkg::WORD_W-1:0] b_num_i,
  input  logic signed [rau_pkg::WORD_W-1:0] b_den_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [rau_pkg::WORD_W-1:0] res_num_o,
  output logic [rau_pkg::DEN_W-1:0]   res_den_o,
  output logic [1:0]                  status_o,
  output logic                        equal_o
);
  import rau_pkg::*;

  state_e state_q, state_d;

  // latched request
  logic [2:0]        kind_q, kind_d;
  logic [WORD_W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;

  // working registers: numerator, second cross product, denominator
  logic [WIDE_W-1:0] p_num_q, p_num_d, p_aux_q, p_aux_d, p_den_q, p_den_d;
  logic              n_sign_q, n_sign_d, d_sign_q, d_sign_d;

  // staged result and output register
  logic [WORD_W-1:0] r_num_q, r_num_d, out_num_q, out_num_d;
  logic [DEN_W-1:0]  r_den_q, r_den_d, out_den_q, out_den_d;
  status_e           r_status_q, r_status_d, out_status_q, out_status_d;
  logic              r_equal_q, r_equal_d, out_equal_q, out_equal_d;
  logic              out_valid_q, out_valid_d;

  // sign and magnitude of the latched operands
  logic              an_s, ad_s, bn_s, bd_s;
  logic [WORD_W-1:0] an_m, ad_m, bn_m, bd_m;

  assign an_s = an_q[WORD_W-1];
  assign ad_s = ad_q[WORD_W-1];
  assign bn_s = bn_q[WORD_W-1];
  assign bd_s = bd_q[WORD_W-1];
  assign an_m = an_s ? (~an_q + 1'b1) : an_q;
  assign ad_m = ad_s ? (~ad_q + 1'b1) : ad_q;
  assign bn_m = bn_s ? (~bn_q + 1'b1) : bn_q;
  assign bd_m = bd_s ? (~bd_q + 1'b1) : bd_q;

  // shared multiplier, operands picked by the sequencer state
  logic [WORD_W-1:0] mul_x, mul_y;
  logic [WIDE_W-1:0] prod;
  assign prod = mul_x * mul_y;

  always_comb begin
    mul_x = ad_m;
    mul_y = bd_m;
    unique case (state_q)
      S_MUL1: begin
        mul_x = an_m;
        mul_y = (kind_q == KIND_MUL) ? bn_m : bd_m;
      end
      S_MUL2: begin
        mul_x = ad_m;
        mul_y = (kind_q == KIND_MUL) ? bd_m : bn_m;
      end
      default: begin
        mul_x = ad_m;
        mul_y = bd_m;
      end
    endcase
  end

  // reduction units
  logic              gcd_start, gcd_done;
  logic [WIDE_W-1:0] gcd_val;
  logic              div_start, div_done;
  logic [WIDE_W-1:0] div_dividend, div_quot;

  assign div_dividend = (state_q == S_GCD) ? p_num_q : p_den_q;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (p_num_q),
    .y_i     (p_den_q),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (gcd_val),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // helper terms
  logic need_b, t1s, t2s, res_s, ovf;

  assign need_b = !(kind_q == KIND_NORM || kind_q == KIND_NEG);
  assign t1s    = an_s ^ bd_s;
  assign t2s    = bn_s ^ ad_s ^ (kind_q == KIND_SUB);
  assign res_s  = n_sign_q ^ d_sign_q;
  assign ovf    = (p_den_q > DEN_MAX) ||
                  (res_s ? (p_num_q > NUM_NEG_MAX) : (p_num_q > NUM_POS_MAX));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    an_d         = an_q;
    ad_d         = ad_q;
    bn_d         = bn_q;
    bd_d         = bd_q;
    p_num_d      = p_num_q;
    p_aux_d      = p_aux_q;
    p_den_d      = p_den_q;
    n_sign_d     = n_sign_q;
    d_sign_d     = d_sign_q;
    r_num_d      = r_num_q;
    r_den_d      = r_den_q;
    r_status_d   = r_status_q;
    r_equal_d    = r_equal_q;
    out_num_d    = out_num_q;
    out_den_d    = out_den_q;
    out_status_d = out_status_q;
    out_equal_d  = out_equal_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    gcd_start    = 1'b0;
    div_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          an_d    = a_num_i;
          ad_d    = a_den_i;
          bn_d    = b_num_i;
          bd_d    = b_den_i;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        // error paths default to an all-zero result
        r_num_d    = '0;
        r_den_d    = '0;
        r_status_d = ST_OK;
        r_equal_d  = 1'b0;
        priority if (kind_q == KIND_UNUSED) begin
          state_d = S_OUT;
        end else if (ad_m == '0 || (need_b && bd_m == '0)) begin
          r_status_d = ST_ZERO_DEN;
          state_d    = S_OUT;
        end else if (kind_q == KIND_DIV && bn_m == '0) begin
          r_status_d = ST_DIV_ZERO;
          state_d    = S_OUT;
        end else if (kind_q == KIND_NORM || kind_q == KIND_NEG) begin
          p_num_d  = {{(WIDE_W-WORD_W){1'b0}}, an_m};
          p_den_d  = {{(WIDE_W-WORD_W){1'b0}}, ad_m};
          n_sign_d = an_s ^ (kind_q == KIND_NEG);
          d_sign_d = ad_s;
          state_d  = S_REDUCE;
        end else if (kind_q == KIND_EQ && (an_m == '0 || bn_m == '0)) begin
          // a zero only equals another zero
          r_equal_d = (an_m == '0) && (bn_m == '0);
          state_d   = S_OUT;
        end else begin
          unique case (kind_q)
            KIND_MUL: begin
              n_sign_d = an_s ^ bn_s;
              d_sign_d = ad_s ^ bd_s;
            end
            KIND_DIV: begin
              n_sign_d = an_s ^ bd_s;
              d_sign_d = ad_s ^ bn_s;
            end
            default: begin
              n_sign_d = t1s;
              d_sign_d = ad_s ^ bd_s;
            end
          endcase
          state_d = S_MUL1;
        end
      end

      S_MUL1: begin
        p_num_d = prod;
        state_d = S_MUL2;
      end

      S_MUL2: begin
        if (kind_q == KIND_MUL || kind_q == KIND_DIV) begin
          p_den_d = prod;
          state_d = S_REDUCE;
        end else begin
          p_aux_d = prod;
          state_d = (kind_q == KIND_EQ) ? S_EQ : S_MUL3;
        end
      end

      S_MUL3: begin
        p_den_d = prod;
        state_d = S_ADD;
      end

      S_ADD: begin
        priority if (t1s == t2s) begin
          p_num_d  = p_num_q + p_aux_q;
          n_sign_d = t1s;
        end else if (p_num_q >= p_aux_q) begin
          p_num_d  = p_num_q - p_aux_q;
          n_sign_d = t1s;
        end else begin
          p_num_d  = p_aux_q - p_num_q;
          n_sign_d = t2s;
        end
        state_d = S_REDUCE;
      end

      S_EQ: begin
        // both nonzero: same sign and equal cross products
        r_equal_d = ((an_s ^ ad_s) == (bn_s ^ bd_s)) && (p_num_q == p_aux_q);
        state_d   = S_OUT;
      end

      S_REDUCE: begin
        if (p_num_q == '0) begin
          r_num_d    = '0;
          r_den_d    = DEN_W'(1);
          r_status_d = ST_OK;
          r_equal_d  = 1'b0;
          state_d    = S_OUT;
        end else begin
          gcd_start = 1'b1;
          state_d   = S_GCD;
        end
      end

      S_GCD: begin
        if (gcd_done) begin
          div_start = 1'b1;
          state_d   = S_DIVN;
        end
      end

      S_DIVN: begin
        if (div_done) begin
          p_num_d   = div_quot;
          div_start = 1'b1;
          state_d   = S_DIVD;
        end
      end

      S_DIVD: begin
        if (div_done) begin
          p_den_d = div_quot;
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        r_equal_d = 1'b0;
        if (ovf) begin
          r_num_d    = '0;
          r_den_d    = '0;
          r_status_d = ST_OVERFLOW;
        end else begin
          r_num_d    = res_s ? (~p_num_q[WORD_W-1:0] + 1'b1) : p_num_q[WORD_W-1:0];
          r_den_d    = p_den_q[DEN_W-1:0];
          r_status_d = ST_OK;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_num_d    = r_num_q;
          out_den_d    = r_den_q;
          out_status_d = r_status_q;
          out_equal_d  = r_equal_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    an_q         <= an_d;
    ad_q         <= ad_d;
    bn_q         <= bn_d;
    bd_q         <= bd_d;
    p_num_q      <= p_num_d;
    p_aux_q      <= p_aux_d;
    p_den_q      <= p_den_d;
    n_sign_q     <= n_sign_d;
    d_sign_q     <= d_sign_d;
    r_num_q      <= r_num_d;
    r_den_q      <= r_den_d;
    r_status_q   <= r_status_d;
    r_equal_q    <= r_equal_d;
    out_num_q    <= out_num_d;
    out_den_q    <= out_den_d;
    out_status_q <= out_status_d;
    out_equal_q  <= out_equal_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = out_num_q;
  assign res_den_o   = out_den_q;
  assign status_o    = out_status_q;
  assign equal_o     = out_equal_q;

endmodule

// ===== rtl/rau_gcd.sv =====
// Binary gcd of two nonzero 64-bit magnitudes, one step per cycle.
// Depends on rau_pkg.
module rau_gcd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rau_pkg::WIDE_W-1:0] x_i,
  input  logic [rau_pkg::WIDE_W-1:0] y_i,
  output logic                       done_o,
  output logic [rau_pkg::WIDE_W-1:0] gcd_o
);
  import rau_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WIDE_W-1:0] u_q, u_d, v_q, v_d, g_q, g_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              u_gt;
  logic [WIDE_W-1:0] dif;

  assign u_gt = u_q > v_q;
  assign dif  = u_gt ? (u_q - v_q) : (v_q - u_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    u_d    = u_q;
    v_d    = v_q;
    k_d    = k_q;
    g_d    = g_q;
    if (start_i) begin
      busy_d = 1'b1;
      u_d    = x_i;
      v_d    = y_i;
      k_d    = '0;
    end else if (busy_q) begin
      priority if (u_q == v_q) begin
        g_d    = u_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!u_q[0] && !v_q[0]) begin
        u_d = u_q >> 1;
        v_d = v_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_d = u_q >> 1;
      end else if (!v_q[0]) begin
        v_d = v_q >> 1;
      end else if (u_gt) begin
        u_d = dif >> 1;
      end else begin
        v_d = dif >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule

// ===== rtl/rau_div.sv =====
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rau_pkg::WIDE_W-1:0] dividend_i,
  input  logic [rau_pkg::WIDE_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [rau_pkg::WIDE_W-1:0] quot_o
);
  import rau_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WIDE_W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [WIDE_W:0]   sh;
  logic [WIDE_W+1:0] diff;
  logic              ge;

  assign sh   = {rem_q, quo_q[WIDE_W-1]};
  assign diff = {1'b0, sh} - {2'b00, dvs_q};
  assign ge   = !diff[WIDE_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[WIDE_W-1:0] : sh[WIDE_W-1:0];
      quo_d = {quo_q[WIDE_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== tb/sv/rational_arithmetic_unit_test.sv =====
// Self-checking bench for rational_arithmetic_unit: directed and random requests.
// Uses rau_pkg for the kind and status codes and a local predictor of each result.
// Depends on rau_pkg, rational_arithmetic_unit, rau_gcd and rau_div under rtl/.
module rational_arithmetic_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  localparam logic [31:0] MIN_W       = 32'h8000_0000;
  localparam logic [31:0] MAX_W       = 32'h7FFF_FFFF;
  localparam int          RAND_OPS    = 1825;
  localparam int          QUIET_TAIL  = 150;   // last requests run without idling
  // Worst legal gap with nothing accepted: a full request's work plus a sender
  // idle burst and a receiver stall. HANG_LIMIT is several times that.
  localparam int          HANG_LIMIT  = 4000;
  localparam int          SETTLE      = 300;   // cycles after the last result

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    bit          drain;   // hold this request until every result is back
  } op_t;

  typedef struct {
    op_t         src;
    logic [31:0] num;
    logic [30:0] den;
    status_e     status;
    logic        equal;
  } fraction_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i     = '0;
  logic [31:0] a_num_i    = '0;
  logic [31:0] a_den_i    = '0;
  logic [31:0] b_num_i    = '0;
  logic [31:0] b_den_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0]  status_o;
  logic        equal_o;

  op_t         op_q[$];        // requests not yet presented
  fraction_t   want_q[$];      // predicted results, oldest first
  op_t         on_wire;        // request currently driven on the inputs
  int unsigned sent_cnt   = 0; // owned by the driver
  int unsigned recv_cnt   = 0; // owned by the monitor
  int unsigned idle_left  = 0;
  int unsigned stall_left = 0;
  int unsigned hang_cnt   = 0;
  int          mismatch_cnt = 0;
  bit          quiet      = 1'b0;

  rational_arithmetic_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .status_o    (status_o),
    .equal_o     (equal_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Two's complement word to sign and 64-bit magnitude; 0x80000000 gives 2^31.
  function automatic void split_mag(input logic [31:0] v, output bit neg,
                                    output logic [63:0] mag);
    neg = v[31];
    mag = {32'd0, (neg ? -v : v)};
  endfunction

  // Divide out the gcd; the sign ends up on the numerator, zero becomes +0/1.
  function automatic void lowest_terms(input bit ns, input logic [63:0] nm,
                                       input bit ds, input logic [63:0] dm,
                                       output bit s, output logic [63:0] n,
                                       output logic [63:0] d);
    logic [63:0] x, y, t;
    if (nm == 0) begin
      s = 1'b0;
      n = 64'd0;
      d = 64'd1;
      return;
    end
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    s = ns != ds;
    n = nm / x;
    d = dm / x;
  endfunction

  function automatic fraction_t reduce_op(op_t op);
    fraction_t   f;
    bit          an_s, ad_s, bn_s, bd_s, ns, ds, s, s2, need_b, t1s, t2s;
    logic [63:0] an_m, ad_m, bn_m, bd_m, nm, dm, n, d, n2, d2, t1m, t2m;
    f.src    = op;
    f.num    = '0;
    f.den    = '0;
    f.status = ST_OK;
    f.equal  = 1'b0;
    if (op.kind == KIND_UNUSED) return f;
    split_mag(op.a_num, an_s, an_m);
    split_mag(op.a_den, ad_s, ad_m);
    split_mag(op.b_num, bn_s, bn_m);
    split_mag(op.b_den, bd_s, bd_m);
    // normalize and negate never look at b
    need_b = !(op.kind == KIND_NORM || op.kind == KIND_NEG);
    if (ad_m == 0 || (need_b && bd_m == 0)) begin
      f.status = ST_ZERO_DEN;
      return f;
    end
    if (op.kind == KIND_EQ) begin
      lowest_terms(an_s, an_m, ad_s, ad_m, s, n, d);
      lowest_terms(bn_s, bn_m, bd_s, bd_m, s2, n2, d2);
      f.equal = (s == s2) && (n == n2) && (d == d2);
      return f;
    end
    case (op.kind)
      KIND_NORM: begin
        ns = an_s; nm = an_m; ds = ad_s; dm = ad_m;
      end
      KIND_NEG: begin
        ns = !an_s; nm = an_m; ds = ad_s; dm = ad_m;
      end
      KIND_ADD, KIND_SUB: begin
        t1s = an_s != bd_s;
        t2s = bn_s != ad_s;
        if (op.kind == KIND_SUB) t2s = !t2s;
        t1m = an_m * bd_m;
        t2m = bn_m * ad_m;
        // sign-magnitude sum; each term is at most 2^62, so nothing wraps
        if (t1s == t2s) begin
          ns = t1s; nm = t1m + t2m;
        end else if (t1m >= t2m) begin
          ns = t1s; nm = t1m - t2m;
        end else begin
          ns = t2s; nm = t2m - t1m;
        end
        ds = ad_s != bd_s;
        dm = ad_m * bd_m;
      end
      KIND_MUL: begin
        ns = an_s != bn_s; nm = an_m * bn_m;
        ds = ad_s != bd_s; dm = ad_m * bd_m;
      end
      default: begin
        if (bn_m == 0) begin
          f.status = ST_DIV_ZERO;
          return f;
        end
        ns = an_s != bd_s; nm = an_m * bd_m;
        ds = ad_s != bn_s; dm = ad_m * bn_m;
      end
    endcase
    lowest_terms(ns, nm, ds, dm, s, n, d);
    if (d > DEN_MAX || (s ? n > NUM_NEG_MAX : n > NUM_POS_MAX)) begin
      f.status = ST_OVERFLOW;
      return f;
    end
    f.num = s ? -n[31:0] : n[31:0];
    f.den = d[30:0];
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_op(input logic [2:0] k, input logic [31:0] an,
                        input logic [31:0] ad, input logic [31:0] bn,
                        input logic [31:0] bd);
    op_t op;
    op.kind  = k;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    op.drain = 1'b0;
    op_q.push_back(op);
  endtask

  // Mostly small values so results reduce and fit; some full-range words
  // and extremes to reach overflow and every bit.
  function automatic logic [31:0] pick_word(bit as_den);
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 99);
    if (as_den && sel < 3) return '0;
    if (sel < 45) begin
      v = int'($urandom_range(0, 120)) - 60;
      return v;
    end
    if (sel < 65) begin
      v = int'($urandom_range(0, 200000)) - 100000;
      return v;
    end
    if (sel < 90) return $urandom();
    case ($urandom_range(0, 5))
      0:       return MIN_W;
      1:       return MAX_W;
      2:       return '0;
      3:       return '1;
      4:       return 32'd1;
      default: return MIN_W + 32'd1;
    endcase
  endfunction

  function automatic op_t random_op();
    op_t op;
    int  k;
    int  d;
    op.drain = 1'b0;
    if ($urandom_range(0, 99) < 4) op.kind = KIND_UNUSED;
    else op.kind = 3'($urandom_range(0, 6));
    op.a_num = pick_word(1'b0);
    op.a_den = pick_word(1'b1);
    op.b_num = pick_word(1'b0);
    op.b_den = pick_word(1'b1);
    // half of the compares get b as a scaled copy of a, so equality shows up
    if (op.kind == KIND_EQ && $urandom_range(0, 1) == 1) begin
      k = $urandom_range(1, 9);
      if ($urandom_range(0, 1) == 1) k = -k;
      d = $urandom_range(1, 2000);
      if ($urandom_range(0, 1) == 1) d = -d;
      op.a_num = int'($urandom_range(0, 2000)) - 1000;
      op.a_den = d;
      op.b_num = $signed(op.a_num) * k;
      op.b_den = $signed(op.a_den) * k;
    end
    if (op.kind == KIND_DIV && $urandom_range(0, 19) == 0) op.b_num = '0;
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents one request at a time, idles in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    op_t         nxt;
    int unsigned sent_now;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i     <= '0;
      a_num_i    <= '0;
      a_den_i    <= '0;
      b_num_i    <= '0;
      b_den_i    <= '0;
      idle_left  <= 0;
      sent_cnt   <= 0;
      quiet      <= 1'b0;
    end else begin
      sent_now = sent_cnt;
      if (in_valid_i && in_ready_o) begin
        want_q.push_back(reduce_op(on_wire));
        sent_now = sent_cnt + 1;
        sent_cnt <= sent_now;
      end
      quiet <= op_q.size() <= QUIET_TAIL;
      if (!in_valid_i || in_ready_o) begin
        if (idle_left != 0) begin
          in_valid_i <= 1'b0;
          idle_left  <= idle_left - 1;
        end else if (op_q.size() == 0 || (op_q[0].drain && sent_now != recv_cnt)) begin
          // nothing left, or a drain request waits for all results to return
          in_valid_i <= 1'b0;
        end else begin
          nxt = op_q.pop_front();
          on_wire    <= nxt;
          kind_i     <= nxt.kind;
          a_num_i    <= nxt.a_num;
          a_den_i    <= nxt.a_den;
          b_num_i    <= nxt.b_num;
          b_den_i    <= nxt.b_den;
          in_valid_i <= 1'b1;
          if (op_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            idle_left <= $urandom_range(1, 17);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls the result side in bursts, checks each accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    fraction_t w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
      recv_cnt    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        recv_cnt <= recv_cnt + 1;
        if (want_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unrequested result: %0d/%0d status %0d equal %0b",
                     $signed(res_num_o), res_den_o, status_o, equal_o);
        end else begin
          w = want_q.pop_front();
          if (res_num_o !== w.num || res_den_o !== w.den ||
              status_o !== w.status || equal_o !== w.equal) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $write("kind %0d a %0d/%0d b %0d/%0d: ",
                     w.src.kind, $signed(w.src.a_num), $signed(w.src.a_den),
                     $signed(w.src.b_num), $signed(w.src.b_den));
              $write("expected %0d/%0d status %0d equal %0b, ",
                     $signed(w.num), w.den, w.status, w.equal);
              $display("got %0d/%0d status %0d equal %0b",
                       $signed(res_num_o), res_den_o, status_o, equal_o);
            end
          end
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 17);
      end
    end
  end

  // Watchdog: any stretch with no request and no result accepted is a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        hang_cnt <= 0;
      end else if (hang_cnt == HANG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        hang_cnt <= hang_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed corners, random mix, then drain and verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    op_t op;
    // normalize: sign moves up, zero becomes 0/1, b ignored even with zero den
    add_op(KIND_NORM, -32'sd10 + 32'sd15, -32'sd10, 32'd0, 32'd0);
    add_op(KIND_NORM, 32'd0, -32'sd7, 32'd1, 32'd1);
    add_op(KIND_NORM, MIN_W, '1, 32'd0, 32'd0);        // -2^31/-1 does not fit
    add_op(KIND_NORM, 32'd1, MIN_W, 32'd1, 32'd1);     // denominator 2^31 too wide
    add_op(KIND_NORM, MIN_W, 32'd2, MAX_W, MIN_W);
    add_op(KIND_NORM, 32'd3, 32'd0, 32'd1, 32'd1);     // zero denominator
    // negate
    add_op(KIND_NEG, MIN_W, 32'd1, 32'd0, 32'd0);      // +2^31 overflows
    add_op(KIND_NEG, MAX_W, '1, MAX_W, MAX_W);
    // add / subtract
    add_op(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    add_op(KIND_ADD, MAX_W, 32'd1, MAX_W, 32'd1);
    add_op(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd0);      // b has zero denominator
    add_op(KIND_SUB, 32'd1, 32'd2, -32'sd2, -32'sd4);  // exact zero
    add_op(KIND_SUB, MIN_W, 32'd1, MAX_W, 32'd1);
    // multiply
    add_op(KIND_MUL, MAX_W, MIN_W, MIN_W, MAX_W);
    add_op(KIND_MUL, MAX_W, 32'd1, MAX_W, 32'd1);
    add_op(KIND_MUL, '1, MAX_W, '1, MAX_W);           // denominator overflow
    // divide
    add_op(KIND_DIV, 32'd3, 32'd4, 32'd0, 32'd5);      // divide by zero
    add_op(KIND_DIV, 32'd0, 32'd1, 32'd0, 32'd0);      // zero den wins over div zero
    add_op(KIND_DIV, -32'sd6, 32'd7, 32'd3, -32'sd14);
    // equality
    add_op(KIND_EQ, 32'd2, 32'd4, -32'sd3, -32'sd6);
    add_op(KIND_EQ, 32'd1, 32'd2, 32'd1, 32'd3);
    add_op(KIND_EQ, 32'd0, 32'd5, 32'd0, -32'sd9);
    add_op(KIND_EQ, MIN_W, MIN_W, 32'd1, 32'd1);
    add_op(KIND_EQ, 32'd1, 32'd2, 32'd1, 32'd0);
    add_op(KIND_UNUSED, '1, '1, '1, '1);

    for (int i = 0; i < RAND_OPS; i++) begin
      op = random_op();
      // let the block run dry at the switch to random traffic and now and then
      op.drain = (i % 300 == 0);
      op_q.push_back(op);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (recv_cnt != sent_cnt) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (mismatch_cnt == 0 && want_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
